// ===== rtl/sewt_pkg.sv =====
// Shared constants and types for the sparse extent write translator.
package sewt_pkg;

   // Fixed geometry
   localparam int MAX_EXTENTS        = 1024;
   localparam int MAX_EXTENT_SECTORS = 64;
   localparam int HEADER_BYTES       = 512;

   localparam int EXT_W    = $clog2(MAX_EXTENTS);          // physical extent number
   localparam int CAT_W    = EXT_W + 1;                    // catalog count, holds MAX_EXTENTS
   localparam int MAP_W    = EXT_W + 1;                    // catalog entry: valid + extent
   localparam int WITHIN_W = $clog2(MAX_EXTENT_SECTORS);   // sector within extent
   localparam int SECTOR_W = 16;
   localparam int MIN_SHIFT = 3;
   localparam int MAX_SHIFT = WITHIN_W;
   localparam int IDX_W    = SECTOR_W - MIN_SHIFT;         // virtual extent index
   localparam int SHIFT_W  = 3;
   localparam int BB_W     = 3;
   localparam int MIN_BB   = 1;
   localparam int MAX_BB   = 4;
   localparam int DISK_W   = SECTOR_W + 1;
   localparam int SPAN_W   = WITHIN_W + 2;                 // sectors + bitmap blocks per extent
   localparam int PROD_W   = EXT_W + SPAN_W;
   localparam int OFF_W    = 26;
   localparam int STATUS_W = 2;
   localparam int BLOCK_SHIFT = 9;                         // 512-byte blocks

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_CATALOG_ENTRIES = 2'd0;
   localparam logic [1:0] REG_EXTENT_SHIFT    = 2'd1;
   localparam logic [1:0] REG_BMP_BLOCKS      = 2'd2;
   localparam logic [1:0] REG_DISK_SECTORS    = 2'd3;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef struct packed {
      logic [CAT_W-1:0]   catalog_entries;
      logic [SHIFT_W-1:0] extent_shift;
      logic [BB_W-1:0]    bmp_blocks;
      logic [DISK_W-1:0]  disk_sectors;
   } sewt_cfg_type;

   typedef struct packed {
      logic clear;    // catalog clearing pass, one entry
      logic start;    // take an item, issue catalog read
      logic lookup;   // catalog data back: check, allocate, issue bitmap read
      logic mark;     // bitmap data back: set bit, write back
      logic finish;   // load result register
   } sewt_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic fail;
      logic out_blocked;
   } sewt_stat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [EXT_W-1:0]    physical_extent;
      logic                newly_allocated;
      logic                bitmap_changed;
      logic [OFF_W-1:0]    bitmap_byte_offset;
      logic [OFF_W-1:0]    block_byte_offset;
   } sewt_result_type;

endpackage

// ===== rtl/sewt_if.sv =====
// Request and response channel interfaces.
interface sewt_req_if;
   import sewt_pkg::*;
   logic                valid;
   logic                ready;
   logic [SECTOR_W-1:0] sector_number;

   modport source (output valid, output sector_number, input ready);
   modport sink   (input valid, input sector_number, output ready);
endinterface

interface sewt_rsp_if;
   import sewt_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [EXT_W-1:0]    physical_extent;
   logic                newly_allocated;
   logic                bitmap_changed;
   logic [OFF_W-1:0]    bitmap_byte_offset;
   logic [OFF_W-1:0]    block_byte_offset;

   modport source (output valid, output status, output physical_extent,
                   output newly_allocated, output bitmap_changed,
                   output bitmap_byte_offset, output block_byte_offset, input ready);
   modport sink   (input valid, input status, input physical_extent,
                   input newly_allocated, input bitmap_changed,
                   input bitmap_byte_offset, input block_byte_offset, output ready);
endinterface

// ===== rtl/sewt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sewt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sewt_ctrl.sv =====
// Sequencing state machine for the extent write translator.
module sewt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sewt_pkg::sewt_stat_type stat,
   output sewt_pkg::sewt_cmd_type  cmd
);
   import sewt_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_MARK   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = stat.fail ? S_FINISH : S_MARK;
         end
         S_MARK: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.out_blocked) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready   = (state_ff == S_IDLE);
   assign cmd.clear  = (state_ff == S_CLEAR);
   assign cmd.start  = (state_ff == S_IDLE) && in_valid;
   assign cmd.lookup = (state_ff == S_LOOKUP);
   assign cmd.mark   = (state_ff == S_MARK);
   assign cmd.finish = (state_ff == S_FINISH) && !stat.out_blocked;

endmodule

// ===== rtl/sewt_datapath.sv =====
// Catalog and bitmap memories, allocation, offset arithmetic and result register.
module sewt_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  sewt_pkg::sewt_cmd_type           cmd,
   output sewt_pkg::sewt_stat_type          stat,
   input  sewt_pkg::sewt_cfg_type           cfg,
   input  logic [sewt_pkg::SECTOR_W-1:0]    in_sector,
   input  logic                             out_ready,
   output logic                             out_valid,
   output sewt_pkg::sewt_result_type        out_result
);
   import sewt_pkg::*;

   // Effective (clamped) configuration
   logic [CAT_W-1:0]   entries;
   logic [SHIFT_W-1:0] shift;
   logic [BB_W-1:0]    bblocks;
   logic [SPAN_W-1:0]  span;

   always_comb begin
      entries = (cfg.catalog_entries > CAT_W'(MAX_EXTENTS)) ?
                CAT_W'(MAX_EXTENTS) : cfg.catalog_entries;
      if (cfg.extent_shift < SHIFT_W'(MIN_SHIFT))      shift = SHIFT_W'(MIN_SHIFT);
      else if (cfg.extent_shift > SHIFT_W'(MAX_SHIFT)) shift = SHIFT_W'(MAX_SHIFT);
      else                                             shift = cfg.extent_shift;
      if (cfg.bmp_blocks < BB_W'(MIN_BB))      bblocks = BB_W'(MIN_BB);
      else if (cfg.bmp_blocks > BB_W'(MAX_BB)) bblocks = BB_W'(MAX_BB);
      else                                     bblocks = cfg.bmp_blocks;
      span = (SPAN_W'(1) << shift) + SPAN_W'(bblocks);
   end

   // Item registers
   logic [SECTOR_W-1:0] sector_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [WITHIN_W-1:0] within_ff, within_in;
   logic [STATUS_W-1:0] status_ff;
   logic [EXT_W-1:0]    phys_ff, phys_in;
   logic                newly_ff;
   logic                changed_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CAT_W-1:0]    next_free_ff;
   logic [EXT_W-1:0]    clr_ff;

   assign idx_in    = IDX_W'(in_sector >> shift);
   assign within_in = WITHIN_W'(in_sector & ~({SECTOR_W{1'b1}} << shift));

   // Catalog memory: {valid, physical extent}
   logic             map_we;
   logic [EXT_W-1:0] map_waddr;
   logic [MAP_W-1:0] map_wdata;
   logic [MAP_W-1:0] map_rdata;

   // Lookup decisions
   logic range_err, idx_err, full_err, fail_c, alloc_c;

   assign range_err = {1'b0, sector_ff} >= cfg.disk_sectors;
   assign idx_err   = idx_ff >= IDX_W'(entries);
   assign full_err  = !map_rdata[EXT_W] && (next_free_ff >= entries);
   assign fail_c    = range_err || idx_err || full_err;
   assign alloc_c   = cmd.lookup && !fail_c && !map_rdata[EXT_W];
   assign phys_in   = map_rdata[EXT_W] ? map_rdata[EXT_W-1:0] : next_free_ff[EXT_W-1:0];

   always_comb begin
      if (cmd.clear) begin
         map_we    = 1'b1;
         map_waddr = clr_ff;
         map_wdata = '0;
      end else begin
         map_we    = alloc_c;
         map_waddr = idx_ff[EXT_W-1:0];
         map_wdata = {1'b1, next_free_ff[EXT_W-1:0]};
      end
   end

   sewt_ram #(.WIDTH(MAP_W), .DEPTH(MAX_EXTENTS)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (idx_in[EXT_W-1:0]),
      .rdata (map_rdata)
   );

   // Sector bitmap memory; an entry is rewritten whole when its extent is allocated
   logic [MAX_EXTENT_SECTORS-1:0] bm_rdata, bm_word, bm_bit;

   assign bm_word = newly_ff ? '0 : bm_rdata;
   assign bm_bit  = MAX_EXTENT_SECTORS'(1) << within_ff;

   sewt_ram #(.WIDTH(MAX_EXTENT_SECTORS), .DEPTH(MAX_EXTENTS)) u_bitmap_ram (
      .clock (clock),
      .we    (cmd.mark),
      .waddr (phys_ff),
      .wdata (bm_word | bm_bit),
      .raddr (phys_in),
      .rdata (bm_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sector_ff <= in_sector;
         idx_ff    <= idx_in;
         within_ff <= within_in;
      end
      if (cmd.lookup) begin
         phys_ff  <= phys_in;
         newly_ff <= alloc_c;
         if (range_err)   status_ff <= ST_RANGE;
         else if (fail_c) status_ff <= ST_FULL;
         else             status_ff <= ST_OK;
      end
      if (cmd.mark) begin
         changed_ff <= (bm_word & bm_bit) == '0;
         prod_ff    <= PROD_W'(phys_ff) * PROD_W'(span);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
         clr_ff       <= '0;
      end else begin
         if (alloc_c) next_free_ff <= next_free_ff + 1'b1;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clr_ff == EXT_W'(MAX_EXTENTS - 1));
   assign stat.fail       = fail_c;

   // Offsets
   logic [OFF_W-1:0] bm_off, blk_off;

   assign bm_off  = OFF_W'(HEADER_BYTES) + OFF_W'({entries, 2'b00})
                  + OFF_W'({prod_ff, {BLOCK_SHIFT{1'b0}}});
   assign blk_off = bm_off
                  + OFF_W'({SPAN_W'(bblocks) + SPAN_W'(within_ff), {BLOCK_SHIFT{1'b0}}});

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   sewt_result_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status_ff;
      if (status_ff == ST_OK) begin
         rsp_in.physical_extent    = phys_ff;
         rsp_in.newly_allocated    = newly_ff;
         rsp_in.bitmap_changed     = changed_ff;
         rsp_in.bitmap_byte_offset = bm_off;
         rsp_in.block_byte_offset  = blk_off;
      end
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (out_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign stat.out_blocked = rsp_valid_ff && !out_ready;
   assign out_valid        = rsp_valid_ff;
   assign out_result       = rsp_ff;

   a_next_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CAT_W'(MAX_EXTENTS))
      else $error("free extent pointer past catalog");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      alloc_c |=> next_free_ff == CAT_W'($past(next_free_ff) + 1'b1))
      else $error("allocation did not advance free pointer");

   a_new_sets_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.newly_allocated |-> rsp_ff.bitmap_changed)
      else $error("new extent without bitmap change");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |->
         !rsp_ff.newly_allocated && !rsp_ff.bitmap_changed && rsp_ff.physical_extent == '0)
      else $error("error result carries mapping data");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !rsp_valid_ff && !alloc_c)
      else $error("activity during catalog clearing");

endmodule

// ===== rtl/sparse_extent_write_translate.sv =====
// Top level of the sparse extent write translator: channels, APB registers, core.
//
// Translates 512-byte sector writes on a thin-provisioned disk image. Each request item
// carries a virtual sector number; the response item reports the physical extent, whether
// the extent was just allocated (zero-fill it and write its catalog entry), whether the
// sector's bitmap bit was newly set (write the bitmap back), and the image byte offsets of
// the extent bitmap and the sector's data block. Status 1 means the sector is at or past
// the disk size, status 2 means the extent index is outside the catalog or the catalog is
// full; error items carry zero in every other field and change no state. An item is
// accepted only when the block is idle, and no new item is taken until it is done; its
// steps are: accept and read the catalog RAM, check and allocate then read the bitmap
// RAM, set the bit and write it back, load the result. The two registered RAM reads lie
// in series. An error item skips the bitmap step. The next item is accepted while a
// result waits in the output register; it then holds in its last step until that result
// is taken. After reset the catalog RAM is swept clear, one entry per cycle, through all
// 1024 entries; no item is accepted in that time, register writes are.
// Registers sit on the APB port at byte addresses 0 (catalog_entries), 4 (extent_shift),
// 8 (bitmap block count) and 12 (disk_sectors); out-of-range values are clamped on use.
module sparse_extent_write_translate (
   input  logic                        clock,
   input  logic                        reset,
   sewt_req_if.sink                    req_chan,
   sewt_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sewt_pkg::PADDR_W-1:0] paddr,
   input  logic [sewt_pkg::PDATA_W-1:0] pwdata,
   output logic [sewt_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);
   import sewt_pkg::*;

   // Configuration registers
   sewt_cfg_type cfg_ff;
   logic         cfg_wr;
   logic [1:0]   reg_sel;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.catalog_entries <= CAT_W'(MAX_EXTENTS);
         cfg_ff.extent_shift    <= SHIFT_W'(MIN_SHIFT);
         cfg_ff.bmp_blocks      <= BB_W'(MIN_BB);
         cfg_ff.disk_sectors    <= DISK_W'(65536);
      end else if (cfg_wr) begin
         case (reg_sel)
            REG_CATALOG_ENTRIES: cfg_ff.catalog_entries <= pwdata[CAT_W-1:0];
            REG_EXTENT_SHIFT:    cfg_ff.extent_shift    <= pwdata[SHIFT_W-1:0];
            REG_BMP_BLOCKS:      cfg_ff.bmp_blocks      <= pwdata[BB_W-1:0];
            REG_DISK_SECTORS:    cfg_ff.disk_sectors    <= pwdata[DISK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CATALOG_ENTRIES: prdata = PDATA_W'(cfg_ff.catalog_entries);
         REG_EXTENT_SHIFT:    prdata = PDATA_W'(cfg_ff.extent_shift);
         REG_BMP_BLOCKS:      prdata = PDATA_W'(cfg_ff.bmp_blocks);
         REG_DISK_SECTORS:    prdata = PDATA_W'(cfg_ff.disk_sectors);
         default:             prdata = '0;
      endcase
   end

   // Controller and datapath
   sewt_cmd_type    cmd;
   sewt_stat_type   stat;
   sewt_result_type result;

   sewt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sewt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg_ff),
      .in_sector  (req_chan.sector_number),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_result (result)
   );

   assign rsp_chan.status             = result.status;
   assign rsp_chan.physical_extent    = result.physical_extent;
   assign rsp_chan.newly_allocated    = result.newly_allocated;
   assign rsp_chan.bitmap_changed     = result.bitmap_changed;
   assign rsp_chan.bitmap_byte_offset = result.bitmap_byte_offset;
   assign rsp_chan.block_byte_offset  = result.block_byte_offset;

endmodule
